// ----- rtl/dtmt_pkg.sv -----
// Shared constants and types for the decaying topic momentum table.
// No dependencies; used by decaying_topic_momentum_table_core.
package dtmt_pkg;

  localparam int SLOTS_DEF   = 16;
  localparam int KEY_W       = 16;
  localparam int MOM_W       = 10;
  localparam int AMT_W       = 10;
  localparam int IDX_OUT_W   = 4;
  localparam int OP_W        = 2;
  localparam int DECAY_SHIFT = 8;

  localparam logic [MOM_W-1:0]       MOM_MAX   = MOM_W'(1000);
  localparam logic [KEY_W-1:0]       NO_KEY    = 16'hFFFF;
  localparam logic [DECAY_SHIFT-1:0] DECAY_MUL = 8'd245;

  typedef enum logic [OP_W-1:0] {
    OP_BOOST = 2'd0,
    OP_DECAY = 2'd1,
    OP_QUERY = 2'd2,
    OP_NONE  = 2'd3
  } opcode_t;

endpackage

// ----- rtl/decaying_topic_momentum_table_core.sv -----
// Decaying topic momentum table: keyed 10-bit counters with boost, decay and query.
// Depends on dtmt_pkg (constants, opcode type).

// One operation may be started in every cycle (start high while busy is low);
// busy is high only during reset and the cycle after it. The input register is
// loaded at the transfer edge and the result register at the next edge, so done
// is high for exactly one cycle per operation, once the result register is loaded.
// The receiver cannot stall, so results must be captured when done is high. The
// table is cleared by reset.
module decaying_topic_momentum_table_core #(
  parameter int SLOTS = dtmt_pkg::SLOTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [dtmt_pkg::OP_W-1:0]       opcode,
  input  logic [dtmt_pkg::KEY_W-1:0]      topic,
  input  logic [dtmt_pkg::AMT_W-1:0]      amount,
  output logic                            done,
  output logic [dtmt_pkg::MOM_W-1:0]      momentum,
  output logic [dtmt_pkg::IDX_OUT_W-1:0]  slot_index,
  output logic                            found,
  output logic                            ignored
);

  localparam int IW = $clog2(SLOTS);
  localparam int P  = 1 << IW;
  localparam int KW = dtmt_pkg::KEY_W;
  localparam int MW = dtmt_pkg::MOM_W;
  localparam int PW = MW + dtmt_pkg::DECAY_SHIFT;

  // input register
  logic                   in_valid;
  dtmt_pkg::opcode_t      in_op;
  logic [KW-1:0]          in_topic;
  logic [dtmt_pkg::AMT_W-1:0] in_amount;

  // table
  logic [KW-1:0] slot_key      [SLOTS];
  logic [MW-1:0] slot_momentum [SLOTS];
  logic [KW-1:0] slot_key_next      [SLOTS];
  logic [MW-1:0] slot_momentum_next [SLOTS];

  logic [SLOTS-1:0] free_v, hit_v, qhit_v;
  logic [SLOTS-1:0] hit_1h, qhit_1h, free_1h;
  logic [IW-1:0]    hit_idx, qhit_idx, free_idx, new_idx;
  logic [MW-1:0]    hit_mom, qhit_mom;
  logic [MW:0]      sum;
  logic [MW-1:0]    sat_sum, amt_cap;
  logic [MW-1:0]    dec [SLOTS];
  logic [PW-1:0]    prod [SLOTS];
  logic [MW-1:0]    tv [2*P];
  logic [IW-1:0]    ti [2*P];
  logic             in_ign, any_hit, any_qhit, any_free;

  logic                         done_next, found_next, ignored_next;
  logic [MW-1:0]                momentum_next;
  logic [dtmt_pkg::IDX_OUT_W-1:0] slot_index_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b1;
      in_valid <= 1'b0;
      done     <= 1'b0;
      for (int i = 0; i < SLOTS; i++) begin
        slot_key[i]      <= '0;
        slot_momentum[i] <= '0;
      end
    end else begin
      busy     <= 1'b0;
      in_valid <= start && !busy;
      done     <= done_next;
      for (int i = 0; i < SLOTS; i++) begin
        slot_key[i]      <= slot_key_next[i];
        slot_momentum[i] <= slot_momentum_next[i];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      in_op     <= dtmt_pkg::opcode_t'(opcode);
      in_topic  <= topic;
      in_amount <= amount;
    end
    momentum   <= momentum_next;
    slot_index <= slot_index_next;
    found      <= found_next;
    ignored    <= ignored_next;
  end

  // slot match and free detection
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      free_v[i] = (slot_key[i] == '0) && (slot_momentum[i] == '0);
      qhit_v[i] = (slot_key[i] == in_topic);
      hit_v[i]  = qhit_v[i] && !free_v[i];
      prod[i]   = PW'(slot_momentum[i]) * PW'(dtmt_pkg::DECAY_MUL);
      dec[i]    = prod[i][PW-1:dtmt_pkg::DECAY_SHIFT];
    end
    hit_1h  = hit_v  & (~hit_v  + SLOTS'(1));
    qhit_1h = qhit_v & (~qhit_v + SLOTS'(1));
    free_1h = free_v & (~free_v + SLOTS'(1));
    any_hit  = |hit_v;
    any_qhit = |qhit_v;
    any_free = |free_v;
    hit_idx  = '0;
    qhit_idx = '0;
    free_idx = '0;
    hit_mom  = '0;
    qhit_mom = '0;
    for (int i = 0; i < SLOTS; i++) begin
      hit_idx  = hit_idx  | (hit_1h[i]  ? IW'(i) : '0);
      qhit_idx = qhit_idx | (qhit_1h[i] ? IW'(i) : '0);
      free_idx = free_idx | (free_1h[i] ? IW'(i) : '0);
      hit_mom  = hit_mom  | (hit_1h[i]  ? slot_momentum[i] : '0);
      qhit_mom = qhit_mom | (qhit_1h[i] ? slot_momentum[i] : '0);
    end
  end

  // lowest-momentum tree, earliest slot wins ties
  always_comb begin
    for (int n = 0; n < P; n++) begin
      tv[n] = '0;
      ti[n] = '0;
    end
    for (int n = P; n < 2 * P; n++) begin
      if (n - P < SLOTS) begin
        tv[n] = slot_momentum[n-P];
        ti[n] = IW'(n - P);
      end else begin
        tv[n] = '1;
        ti[n] = '0;
      end
    end
    for (int n = P - 1; n >= 1; n--) begin
      if (tv[2*n] <= tv[2*n+1]) begin
        tv[n] = tv[2*n];
        ti[n] = ti[2*n];
      end else begin
        tv[n] = tv[2*n+1];
        ti[n] = ti[2*n+1];
      end
    end
  end

  always_comb begin
    in_ign  = (in_topic == dtmt_pkg::NO_KEY);
    sum     = {1'b0, hit_mom} + (MW+1)'(in_amount);
    sat_sum = (sum > (MW+1)'(dtmt_pkg::MOM_MAX)) ? dtmt_pkg::MOM_MAX : sum[MW-1:0];
    amt_cap = (in_amount > dtmt_pkg::MOM_MAX) ? dtmt_pkg::MOM_MAX : MW'(in_amount);
    new_idx = any_free ? free_idx : ti[1];

    for (int i = 0; i < SLOTS; i++) begin
      slot_key_next[i]      = slot_key[i];
      slot_momentum_next[i] = slot_momentum[i];
    end
    done_next       = in_valid;
    momentum_next   = '0;
    slot_index_next = '0;
    found_next      = 1'b0;
    ignored_next    = 1'b0;

    if (in_valid) begin
      unique case (in_op)
        dtmt_pkg::OP_DECAY: begin
          for (int i = 0; i < SLOTS; i++) begin
            slot_momentum_next[i] = dec[i];
            if (dec[i] == '0) slot_key_next[i] = '0;
          end
        end
        dtmt_pkg::OP_BOOST: begin
          if (in_ign) begin
            ignored_next = 1'b1;
          end else if (any_hit) begin
            for (int i = 0; i < SLOTS; i++) begin
              if (hit_1h[i]) slot_momentum_next[i] = sat_sum;
            end
            momentum_next   = sat_sum;
            slot_index_next = dtmt_pkg::IDX_OUT_W'(hit_idx);
            found_next      = 1'b1;
          end else begin
            for (int i = 0; i < SLOTS; i++) begin
              if (new_idx == IW'(i)) begin
                slot_key_next[i]      = in_topic;
                slot_momentum_next[i] = amt_cap;
              end
            end
            momentum_next   = amt_cap;
            slot_index_next = dtmt_pkg::IDX_OUT_W'(new_idx);
          end
        end
        dtmt_pkg::OP_QUERY: begin
          if (in_ign) begin
            ignored_next = 1'b1;
          end else if (any_qhit) begin
            momentum_next   = qhit_mom;
            slot_index_next = dtmt_pkg::IDX_OUT_W'(qhit_idx);
            found_next      = 1'b1;
          end
        end
        dtmt_pkg::OP_NONE: begin
        end
        default: begin
        end
      endcase
    end
  end

endmodule

// ----- tb/tb_decaying_topic_momentum_table_core.sv -----
`timescale 1ns / 100ps
// Self-checking testbench for decaying_topic_momentum_table_core: directed and random
// boost, decay and query transfers, each reply checked against a table predictor.
// Depends on dtmt_pkg and the core RTL only.

module tb_decaying_topic_momentum_table_core;

  localparam int              MOM_CAP     = 1000;
  localparam int              DECAY_NUM   = 245;
  localparam logic [dtmt_pkg::KEY_W-1:0] NONE_KEY = 16'hFFFF;
  localparam int              POOL        = 24;
  localparam int              RAND_ITEMS  = 400;
  localparam int              CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic [dtmt_pkg::MOM_W-1:0]     mom;
    logic [dtmt_pkg::IDX_OUT_W-1:0] idx;
    logic                           fnd;
    logic                           ign;
  } reply_t;

  class momentum_table_checker;
    logic [dtmt_pkg::KEY_W-1:0] key_tbl [dtmt_pkg::SLOTS_DEF];
    logic [dtmt_pkg::MOM_W-1:0] mom_tbl [dtmt_pkg::SLOTS_DEF];
    reply_t           replies_due [$];
    int               errors;
    int               replies_seen;

    function new();
      errors = 0;
      replies_seen = 0;
      foreach (key_tbl[i]) begin
        key_tbl[i] = '0;
        mom_tbl[i] = '0;
      end
    endfunction

    function reply_t apply_op(dtmt_pkg::opcode_t op, logic [dtmt_pkg::KEY_W-1:0] key,
                              logic [dtmt_pkg::AMT_W-1:0] amt);
      reply_t r;
      int     free_slot;
      int     low_slot;
      int     low_val;
      int     val;
      int     slot;
      r = '0;
      if (op == dtmt_pkg::OP_DECAY) begin
        for (int i = 0; i < dtmt_pkg::SLOTS_DEF; i++) begin
          val = (int'(mom_tbl[i]) * DECAY_NUM) >> 8;
          mom_tbl[i] = dtmt_pkg::MOM_W'(val);
          if (val == 0) key_tbl[i] = '0;
        end
      end else if ((op == dtmt_pkg::OP_BOOST || op == dtmt_pkg::OP_QUERY) &&
                   key == NONE_KEY) begin
        r.ign = 1'b1;
      end else if (op == dtmt_pkg::OP_BOOST) begin
        free_slot = -1;
        low_slot  = 0;
        low_val   = 1 << 30;
        for (int i = 0; i < dtmt_pkg::SLOTS_DEF; i++) begin
          if (key_tbl[i] == '0 && mom_tbl[i] == '0) begin
            if (free_slot < 0) free_slot = i;
          end else if (key_tbl[i] == key) begin
            val = int'(mom_tbl[i]) + int'(amt);
            if (val > MOM_CAP) val = MOM_CAP;
            mom_tbl[i] = dtmt_pkg::MOM_W'(val);
            r.mom = dtmt_pkg::MOM_W'(val);
            r.idx = dtmt_pkg::IDX_OUT_W'(i);
            r.fnd = 1'b1;
            return r;
          end else if (int'(mom_tbl[i]) < low_val) begin
            low_val  = int'(mom_tbl[i]);
            low_slot = i;
          end
        end
        slot = (free_slot >= 0) ? free_slot : low_slot;
        val  = (int'(amt) > MOM_CAP) ? MOM_CAP : int'(amt);
        key_tbl[slot] = key;
        mom_tbl[slot] = dtmt_pkg::MOM_W'(val);
        r.mom = dtmt_pkg::MOM_W'(val);
        r.idx = dtmt_pkg::IDX_OUT_W'(slot);
      end else if (op == dtmt_pkg::OP_QUERY) begin
        for (int i = 0; i < dtmt_pkg::SLOTS_DEF; i++) begin
          if (key_tbl[i] == key) begin
            r.mom = mom_tbl[i];
            r.idx = dtmt_pkg::IDX_OUT_W'(i);
            r.fnd = 1'b1;
            return r;
          end
        end
      end
      return r;
    endfunction

    function void note_op(dtmt_pkg::opcode_t op, logic [dtmt_pkg::KEY_W-1:0] key,
                          logic [dtmt_pkg::AMT_W-1:0] amt);
      replies_due.push_back(apply_op(op, key, amt));
    endfunction

    function void compare_field(string name, int exp_val, int act_val);
      if (exp_val != act_val) begin
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_val, act_val);
        errors++;
      end
    endfunction

    function void check_reply(reply_t got);
      reply_t exp_r;
      replies_seen++;
      if (replies_due.size() == 0) begin
        $display("%0t: reply with none outstanding, expected nothing, got mom %0d idx %0d",
                 $time, got.mom, got.idx);
        errors++;
      end else begin
        exp_r = replies_due.pop_front();
        compare_field("momentum", exp_r.mom, got.mom);
        compare_field("slot_index", exp_r.idx, got.idx);
        compare_field("found", exp_r.fnd, got.fnd);
        compare_field("ignored", exp_r.ign, got.ign);
      end
    endfunction
  endclass

  logic                           clk    = 1'b0;
  logic                           rst    = 1'b1;
  logic                           start  = 1'b0;
  logic [dtmt_pkg::OP_W-1:0]      opcode = '0;
  logic [dtmt_pkg::KEY_W-1:0]     topic  = '0;
  logic [dtmt_pkg::AMT_W-1:0]     amount = '0;
  logic                           busy;
  logic                           done;
  logic [dtmt_pkg::MOM_W-1:0]     momentum;
  logic [dtmt_pkg::IDX_OUT_W-1:0] slot_index;
  logic                           found;
  logic                           ignored;

  momentum_table_checker          chk;
  logic [dtmt_pkg::KEY_W-1:0]     key_pool [POOL];
  int                             issued = 0;
  int                             cycles = 0;

  decaying_topic_momentum_table_core DUT (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .opcode    (opcode),
    .topic     (topic),
    .amount    (amount),
    .done      (done),
    .momentum  (momentum),
    .slot_index(slot_index),
    .found     (found),
    .ignored   (ignored)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) chk.note_op(dtmt_pkg::opcode_t'(opcode), topic, amount);
      if (done) chk.check_reply(reply_t'({momentum, slot_index, found, ignored}));
    end
  end

  task automatic send_op(dtmt_pkg::opcode_t op, logic [dtmt_pkg::KEY_W-1:0] key,
                         logic [dtmt_pkg::AMT_W-1:0] amt);
    start  <= 1'b1;
    opcode <= op;
    topic  <= key;
    amount <= amt;
    do @(posedge clk); while (busy);
    issued++;
  endtask

  // fields carry junk while start is low
  task automatic pause(int n);
    start  <= 1'b0;
    opcode <= dtmt_pkg::OP_W'($urandom);
    topic  <= dtmt_pkg::KEY_W'($urandom);
    amount <= dtmt_pkg::AMT_W'($urandom);
    repeat (n) @(posedge clk);
  endtask

  task automatic drain_replies();
    start <= 1'b0;
    while (chk.replies_seen < issued) @(posedge clk);
  endtask

  task automatic random_op();
    dtmt_pkg::opcode_t          op;
    logic [dtmt_pkg::KEY_W-1:0] key;
    logic [dtmt_pkg::AMT_W-1:0] amt;
    int                         r;
    r = $urandom_range(0, 99);
    op = (r < 50) ? dtmt_pkg::OP_BOOST : (r < 82) ? dtmt_pkg::OP_QUERY :
         (r < 96) ? dtmt_pkg::OP_DECAY : dtmt_pkg::OP_NONE;
    r = $urandom_range(0, 99);
    if (r < 75)      key = key_pool[$urandom_range(0, POOL - 1)];
    else if (r < 92) key = dtmt_pkg::KEY_W'($urandom);
    else if (r < 96) key = NONE_KEY;
    else             key = '0;
    r = $urandom_range(0, 99);
    if (r < 40)      amt = dtmt_pkg::AMT_W'($urandom_range(0, 40));
    else if (r < 80) amt = dtmt_pkg::AMT_W'($urandom);
    else if (r < 90) amt = dtmt_pkg::AMT_W'($urandom_range(1000, 1023));
    else             amt = dtmt_pkg::AMT_W'($urandom_range(0, 300));
    send_op(op, key, amt);
  endtask

  initial begin
    bit idle_on;
    chk = new();
    key_pool[0] = '0;
    key_pool[1] = 16'hFFFE;
    for (int i = 2; i < POOL; i++)
      key_pool[i] = dtmt_pkg::KEY_W'($urandom_range(1, 16'hFFFE));
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    send_op(dtmt_pkg::OP_QUERY, 16'h0000, 10'd0);
    send_op(dtmt_pkg::OP_BOOST, NONE_KEY, 10'd5);
    send_op(dtmt_pkg::OP_QUERY, NONE_KEY, 10'd0);
    send_op(dtmt_pkg::OP_BOOST, 16'h0001, 10'd1000);
    send_op(dtmt_pkg::OP_BOOST, 16'h0001, 10'd1);
    send_op(dtmt_pkg::OP_BOOST, 16'h0002, 10'd1023);
    send_op(dtmt_pkg::OP_BOOST, 16'h0000, 10'd1);
    send_op(dtmt_pkg::OP_NONE, NONE_KEY, 10'd1023);
    send_op(dtmt_pkg::OP_DECAY, 16'h0000, 10'd0);
    send_op(dtmt_pkg::OP_QUERY, 16'h0000, 10'd0);
    // fill the free slots, then force replacement of the earliest lowest
    for (int i = 0; i < 14; i++)
      send_op(dtmt_pkg::OP_BOOST, 16'h0100 + dtmt_pkg::KEY_W'(i),
              (i == 5 || i == 9) ? 10'd20 : dtmt_pkg::AMT_W'(100 + i));
    send_op(dtmt_pkg::OP_BOOST, 16'h0200, 10'd7);
    send_op(dtmt_pkg::OP_BOOST, 16'h0109, 10'd1);
    drain_replies();

    idle_on = 1'b0;
    for (int k = 0; k < RAND_ITEMS; k++) begin
      if (k % 40 == 0) idle_on = ($urandom_range(0, 2) != 0);
      random_op();
      if (k == RAND_ITEMS / 2)
        drain_replies();
      else if (idle_on && k < RAND_ITEMS - 60 && $urandom_range(0, 3) == 0)
        pause($urandom_range(1, 15));
    end

    drain_replies();
    repeat (8) @(posedge clk);
    if (chk.errors == 0 && chk.replies_due.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/dtmt_pkg.sv
rtl/decaying_topic_momentum_table_core.sv
tb/tb_decaying_topic_momentum_table_core.sv
